// ===== rtl/ip_address_text_parser_macros.svh =====
// Assertion macros for the IP address text parser.
// Included by the top level; no other dependencies.
`ifndef IP_ADDRESS_TEXT_PARSER_MACROS_SVH
`define IP_ADDRESS_TEXT_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
`define IPAT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define IPAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define IPAT_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define IPAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/ipat_pkg.sv =====
// Shared types and constants of the IP address text parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ipat_pkg;

   localparam int NUM_GROUPS = 8;

   // Position of the parser relative to colons in IPv6 text.
   localparam logic [1:0] PH_START       = 2'd0;
   localparam logic [1:0] PH_AFTER_COLON = 2'd1;
   localparam logic [1:0] PH_AFTER_GAP   = 2'd2;
   localparam logic [1:0] PH_IN_GROUP    = 2'd3;

   localparam logic [1:0] FAMILY_IPV4 = 2'd0;
   localparam logic [1:0] FAMILY_IPV6 = 2'd1;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED   = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   localparam logic [8:0]  DEC_LIMIT = 9'd255;
   localparam logic [8:0]  DEC_SAT   = 9'd256;
   localparam logic [16:0] HEX_LIMIT = 17'h0FFFF;

   // Bit positions in field_flags.
   localparam int FLAG_DIGIT  = 0;
   localparam int FLAG_LETTER = 1;
   localparam int FLAG_OVER   = 2;

   typedef logic [15:0] group_type;
   typedef group_type [0:NUM_GROUPS-1] group_row_type;

   typedef struct packed {
      logic [1:0]  active_family;
      logic [1:0]  colon_phase;
      logic        parse_error;
      logic [3:0]  group_count;
      logic        gap_seen;
      logic [2:0]  gap_position;
      logic [16:0] hex_value;
      logic [8:0]  decimal_value;
      logic [2:0]  field_flags;
      logic        dotted_mode;
      logic [1:0]  octet_count;
      logic [23:0] octet_store;
   } ctrl_type;

   localparam ctrl_type CTRL_IDLE = '0;

endpackage

// ===== rtl/ipat_parse_core.sv =====
// Per-character parse state of the IP address text parser.
// Holds the control state and the head and tail group rows; uses ipat_pkg.
`timescale 1ns / 1ps

module ipat_parse_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              character,
   input  logic [1:0]              family,
   output ipat_pkg::ctrl_type      ctrl,
   output ipat_pkg::group_row_type head,
   output ipat_pkg::group_row_type tail
);

   typedef struct packed {
      logic       valid;
      logic       decimal;
      logic [3:0] value;
   } digit_type;

   ipat_pkg::ctrl_type      ctrl_ff, ctrl_in;
   ipat_pkg::group_row_type head_ff, tail_ff;
   logic                    group_we;
   digit_type               dig;
   logic [1:0]              fam;

   function automatic digit_type decode_digit(input logic [7:0] ch);
      digit_type r;
      r = '0;
      if (ch >= ipat_pkg::CHAR_ZERO && ch <= ipat_pkg::CHAR_NINE) begin
         r.valid   = 1'b1;
         r.decimal = 1'b1;
         r.value   = 4'(ch - ipat_pkg::CHAR_ZERO);
      end else if (ch >= ipat_pkg::CHAR_LOWER_A && ch <= ipat_pkg::CHAR_LOWER_F) begin
         r.valid = 1'b1;
         r.value = 4'(ch - ipat_pkg::CHAR_LOWER_A + 8'd10);
      end else if (ch >= ipat_pkg::CHAR_UPPER_A && ch <= ipat_pkg::CHAR_UPPER_F) begin
         r.valid = 1'b1;
         r.value = 4'(ch - ipat_pkg::CHAR_UPPER_A + 8'd10);
      end
      return r;
   endfunction

   function automatic ipat_pkg::ctrl_type clear_field(input ipat_pkg::ctrl_type c_i);
      ipat_pkg::ctrl_type c;
      c = c_i;
      c.hex_value     = '0;
      c.decimal_value = '0;
      c.field_flags   = '0;
      return c;
   endfunction

   // A decimal field saturates at 256 and remembers that it went out of range.
   function automatic ipat_pkg::ctrl_type add_decimal(input ipat_pkg::ctrl_type c_i,
                                                     input logic [3:0] d);
      ipat_pkg::ctrl_type c;
      logic [11:0]        v;
      c = c_i;
      v = 12'(c.decimal_value) * 12'd10 + 12'(d);
      if (v > 12'(ipat_pkg::DEC_LIMIT)) begin
         v = 12'(ipat_pkg::DEC_SAT);
         c.field_flags[ipat_pkg::FLAG_OVER] = 1'b1;
      end
      c.decimal_value = v[8:0];
      c.field_flags[ipat_pkg::FLAG_DIGIT] = 1'b1;
      return c;
   endfunction

   function automatic ipat_pkg::ctrl_type add_hex(input ipat_pkg::ctrl_type c_i,
                                                 input digit_type d);
      ipat_pkg::ctrl_type c;
      logic [16:0]        h;
      c = c_i;
      h = {c.hex_value[12:0], d.value};
      c.hex_value = h;
      if (h > ipat_pkg::HEX_LIMIT) begin
         c.parse_error = 1'b1;
      end
      if (d.decimal) begin
         c = add_decimal(c, d.value);
      end else begin
         c.field_flags[ipat_pkg::FLAG_LETTER] = 1'b1;
         c.field_flags[ipat_pkg::FLAG_DIGIT]  = 1'b1;
      end
      return c;
   endfunction

   function automatic ipat_pkg::ctrl_type step_dotted(input ipat_pkg::ctrl_type c_i,
                                                     input logic [7:0] ch,
                                                     input digit_type d);
      ipat_pkg::ctrl_type c;
      c = c_i;
      if (d.decimal) begin
         c = add_decimal(c, d.value);
      end else if (ch == ipat_pkg::CHAR_DOT) begin
         if (!c.field_flags[ipat_pkg::FLAG_DIGIT] || c.field_flags[ipat_pkg::FLAG_OVER] ||
             c.octet_count == 2'd3) begin
            c.parse_error = 1'b1;
         end else begin
            c.octet_store = {c.octet_store[15:0], c.decimal_value[7:0]};
            c.octet_count = c.octet_count + 2'd1;
            c = clear_field(c);
         end
      end else begin
         c.parse_error = 1'b1;
      end
      return c;
   endfunction

   always_comb begin
      dig      = decode_digit(character);
      fam      = (ctrl_ff.colon_phase == ipat_pkg::PH_START) ? family : ctrl_ff.active_family;
      ctrl_in  = ctrl_ff;
      group_we = 1'b0;
      ctrl_in.active_family = fam;
      if (character == ipat_pkg::CHAR_NUL) begin
         ctrl_in = ipat_pkg::CTRL_IDLE;
      end else begin
         if (!ctrl_ff.parse_error) begin
            if (fam == ipat_pkg::FAMILY_IPV4 ||
                (fam == ipat_pkg::FAMILY_IPV6 && ctrl_ff.dotted_mode)) begin
               ctrl_in = step_dotted(ctrl_in, character, dig);
            end else if (fam == ipat_pkg::FAMILY_IPV6) begin
               if (ctrl_ff.colon_phase != ipat_pkg::PH_IN_GROUP) begin
                  if (character == ipat_pkg::CHAR_COLON) begin
                     if (ctrl_ff.colon_phase == ipat_pkg::PH_START) begin
                        ctrl_in.colon_phase = ipat_pkg::PH_AFTER_COLON;
                     end else if (ctrl_ff.colon_phase == ipat_pkg::PH_AFTER_COLON &&
                                  !ctrl_ff.gap_seen) begin
                        ctrl_in.gap_seen     = 1'b1;
                        ctrl_in.gap_position = ctrl_ff.group_count[2:0];
                        ctrl_in.colon_phase  = ipat_pkg::PH_AFTER_GAP;
                     end else begin
                        ctrl_in.parse_error = 1'b1;
                     end
                  end else if (dig.valid &&
                               !(ctrl_ff.colon_phase == ipat_pkg::PH_AFTER_COLON &&
                                 ctrl_ff.group_count == 4'd0)) begin
                     ctrl_in = clear_field(ctrl_in);
                     ctrl_in = add_hex(ctrl_in, dig);
                     ctrl_in.colon_phase = ipat_pkg::PH_IN_GROUP;
                  end else begin
                     ctrl_in.parse_error = 1'b1;
                  end
               end else if (dig.valid) begin
                  ctrl_in = add_hex(ctrl_in, dig);
               end else if (character == ipat_pkg::CHAR_COLON) begin
                  group_we = 1'b1;
                  ctrl_in.group_count = ctrl_ff.group_count + 4'd1;
                  if (ctrl_in.group_count >= 4'(ipat_pkg::NUM_GROUPS)) begin
                     ctrl_in.parse_error = 1'b1;
                  end else begin
                     ctrl_in.colon_phase = ipat_pkg::PH_AFTER_COLON;
                  end
               end else if (character == ipat_pkg::CHAR_DOT) begin
                  // An embedded IPv4 tail needs room for two groups.
                  if (ctrl_ff.field_flags[ipat_pkg::FLAG_OVER] ||
                      ctrl_ff.field_flags[ipat_pkg::FLAG_LETTER] ||
                      ctrl_ff.group_count > 4'd6) begin
                     ctrl_in.parse_error = 1'b1;
                  end else begin
                     ctrl_in.dotted_mode = 1'b1;
                     ctrl_in.octet_store = {16'd0, ctrl_ff.decimal_value[7:0]};
                     ctrl_in.octet_count = 2'd1;
                     ctrl_in = clear_field(ctrl_in);
                  end
               end else begin
                  ctrl_in.parse_error = 1'b1;
               end
            end
         end
         if (ctrl_in.colon_phase == ipat_pkg::PH_START) begin
            ctrl_in.colon_phase = ipat_pkg::PH_IN_GROUP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= ipat_pkg::CTRL_IDLE;
      end else if (step) begin
         ctrl_ff <= ctrl_in;
      end
   end

   // Groups before the gap land at their own slot; groups after it shift
   // through the tail row so that they end up right aligned.
   always_ff @(posedge clock) begin
      if (step && group_we) begin
         if (ctrl_ff.gap_seen) begin
            tail_ff <= {tail_ff[1:ipat_pkg::NUM_GROUPS-1], ctrl_ff.hex_value[15:0]};
         end else begin
            head_ff[ctrl_ff.group_count[2:0]] <= ctrl_ff.hex_value[15:0];
         end
      end
   end

   assign ctrl = ctrl_ff;
   assign head = head_ff;
   assign tail = tail_ff;

endmodule

// ===== rtl/ipat_assemble.sv =====
// End-of-string checks and address assembly of the IP address text parser.
// Combinational; takes the parse state from ipat_parse_core; uses ipat_pkg.
`timescale 1ns / 1ps

module ipat_assemble (
   input  ipat_pkg::ctrl_type      ctrl,
   input  ipat_pkg::group_row_type head,
   input  ipat_pkg::group_row_type tail,
   input  logic [1:0]              family,
   output logic [1:0]              status,
   output logic [63:0]             address_high,
   output logic [63:0]             address_low
);

   logic [1:0]              fam;
   logic                    v4_ok;
   logic [31:0]             v4_word;
   logic                    fin_ok;
   logic [1:0]              fin_n;
   logic [15:0]             fin_hi, fin_lo;
   logic [3:0]              count_f, tail_n;
   logic                    shape_ok;
   ipat_pkg::group_row_type tail_eff, groups;

   always_comb begin
      fam     = (ctrl.colon_phase == ipat_pkg::PH_START) ? family : ctrl.active_family;
      v4_ok   = ctrl.field_flags[ipat_pkg::FLAG_DIGIT] && !ctrl.field_flags[ipat_pkg::FLAG_OVER]
                && ctrl.octet_count == 2'd3;
      v4_word = {ctrl.octet_store, ctrl.decimal_value[7:0]};

      // The groups still open at the terminator: one hex group, a dotted tail, or none after a gap.
      fin_ok = 1'b0;
      fin_n  = 2'd0;
      if (ctrl.dotted_mode) begin
         fin_ok = v4_ok;
         fin_n  = 2'd2;
      end else if (ctrl.colon_phase == ipat_pkg::PH_IN_GROUP) begin
         fin_ok = 1'b1;
         fin_n  = 2'd1;
      end else if (ctrl.colon_phase == ipat_pkg::PH_AFTER_GAP) begin
         fin_ok = 1'b1;
      end
      fin_hi  = ctrl.dotted_mode ? v4_word[31:16] : ctrl.hex_value[15:0];
      fin_lo  = v4_word[15:0];
      count_f = ctrl.group_count + 4'(fin_n);
      shape_ok = ctrl.gap_seen ? (count_f <= 4'd7) : (count_f == 4'(ipat_pkg::NUM_GROUPS));
      tail_n  = count_f - {1'b0, ctrl.gap_position};

      unique case (fin_n)
         2'd1:    tail_eff = {tail[1:ipat_pkg::NUM_GROUPS-1], fin_hi};
         2'd2:    tail_eff = {tail[2:ipat_pkg::NUM_GROUPS-1], fin_hi, fin_lo};
         default: tail_eff = tail;
      endcase

      for (int k = 0; k < ipat_pkg::NUM_GROUPS; k++) begin
         if (ctrl.gap_seen) begin
            if (4'(k) < {1'b0, ctrl.gap_position}) begin
               groups[k] = head[k];
            end else if (4'(k) + tail_n >= 4'(ipat_pkg::NUM_GROUPS)) begin
               groups[k] = tail_eff[k];
            end else begin
               groups[k] = '0;
            end
         end else begin
            groups[k] = head[k];
         end
      end
      // Without a gap a valid string has its last group or two in fixed slots.
      if (!ctrl.gap_seen) begin
         if (ctrl.dotted_mode) begin
            groups[ipat_pkg::NUM_GROUPS-2] = fin_hi;
            groups[ipat_pkg::NUM_GROUPS-1] = fin_lo;
         end else if (fin_n == 2'd1) begin
            groups[ipat_pkg::NUM_GROUPS-1] = fin_hi;
         end
      end

      status       = ipat_pkg::STATUS_MALFORMED;
      address_high = '0;
      address_low  = '0;
      if (fam[1]) begin
         status = ipat_pkg::STATUS_UNSUPPORTED;
      end else if (!ctrl.parse_error) begin
         if (fam == ipat_pkg::FAMILY_IPV4) begin
            if (v4_ok) begin
               status      = ipat_pkg::STATUS_OK;
               address_low = {32'd0, v4_word};
            end
         end else if (fin_ok && shape_ok) begin
            status       = ipat_pkg::STATUS_OK;
            address_high = {groups[0], groups[1], groups[2], groups[3]};
            address_low  = {groups[4], groups[5], groups[6], groups[7]};
         end
      end
   end

endmodule

// ===== rtl/ip_address_text_parser.sv =====
// IP address text parser, top level: input stage, parse core, result register.
// Depends on ipat_pkg, ipat_parse_core, ipat_assemble and the macros header.
//
// Usage: send an address string one character per request transaction on
// req_character, with its family on req_family (0 IPv4, 1 IPv6, other values
// unsupported); the family is taken from the first character of each string.
// A zero character ends the string. Each terminator yields one response
// transaction with rsp_status (0 valid, 1 malformed, 2 unsupported family)
// and the 128-bit address on rsp_address_high and rsp_address_low; other
// characters yield nothing. Failed strings report an all-zero address.
// Throughput: one character per cycle while req_stall is low, since each
// character only updates a few small accumulators in one pass through the
// parse logic. A terminator accepted on the request side is loaded into the
// input register, and its response is then registered in the result
// register, from which the receiver takes it.
// Reset clears the parse state and both valid bits; any partial string is lost.
// When the receiver stalls a waiting response, req_stall is raised and the
// whole block holds until the response is taken.
`timescale 1ns / 1ps
`include "ip_address_text_parser_macros.svh"

module ip_address_text_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic [1:0]  req_family,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_address_high,
   output logic [63:0] rsp_address_low
);

   logic                    advance;
   logic                    in_valid_ff;
   logic [7:0]              in_char_ff;
   logic [1:0]              in_family_ff;
   logic                    step;
   logic                    term;
   ipat_pkg::ctrl_type      ctrl;
   ipat_pkg::group_row_type head, tail;
   logic [1:0]              status_in;
   logic [63:0]             high_in, low_in;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [63:0]             rsp_high_ff, rsp_low_ff;

   // Everything moves together unless a finished response is held back.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign step      = advance && in_valid_ff;
   assign term      = in_valid_ff && in_char_ff == ipat_pkg::CHAR_NUL;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_char_ff   <= req_character;
         in_family_ff <= req_family;
      end
   end

   ipat_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .character (in_char_ff),
      .family    (in_family_ff),
      .ctrl      (ctrl),
      .head      (head),
      .tail      (tail)
   );

   ipat_assemble u_assemble (
      .ctrl         (ctrl),
      .head         (head),
      .tail         (tail),
      .family       (in_family_ff),
      .status       (status_in),
      .address_high (high_in),
      .address_low  (low_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= term;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && term) begin
         rsp_status_ff <= status_in;
         rsp_high_ff   <= high_in;
         rsp_low_ff    <= low_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_address_high = rsp_high_ff;
   assign rsp_address_low  = rsp_low_ff;

   `IPAT_ASSERT_NEXT(a_term_gives_rsp, clock, reset, step && term, rsp_valid_ff, "terminator lost")
   `IPAT_ASSERT_NEXT(a_term_clears, clock, reset, step && term, ctrl.colon_phase == ipat_pkg::PH_START && !ctrl.parse_error, "parse state not cleared")
   `IPAT_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ipat_pkg::STATUS_OK, rsp_high_ff == 64'd0 && rsp_low_ff == 64'd0, "failed response has address")

endmodule
